/* hdl/divisor_count_trial_assert.svh */
// ---------------------------------------------------------------------------
// divisor_count_trial assertion macros
// Shorthand for clocked implication checks used by the divisor counter.
// ---------------------------------------------------------------------------
`ifndef DIVISOR_COUNT_TRIAL_ASSERT_SVH
`define DIVISOR_COUNT_TRIAL_ASSERT_SVH

// same-cycle implication
`define DCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divisor_count_trial: same-cycle check failed");

// next-cycle implication
`define DCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divisor_count_trial: next-cycle check failed");

`endif

/* hdl/dct_pkg.sv */
// ---------------------------------------------------------------------------
// dct_pkg
// Types and constants shared by the divisor counter modules.
// ---------------------------------------------------------------------------
package dct_pkg;

   localparam int NUMBER_WIDTH    = 31;
   localparam int TOTAL_WIDTH     = 11;
   localparam int REQ_TDATA_WIDTH = 32;
   localparam int RSP_TDATA_WIDTH = 16;

   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = 11'h7FF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* hdl/divisor_count_trial.sv */
// ---------------------------------------------------------------------------
// divisor_count_trial
// Counts the distinct divisors of an integer by trial division.
// ---------------------------------------------------------------------------
// One word in on req_, one word out on rsp_. The low NUM_WIDTH bits of the
// number are used. Candidates i = 1, 2, ... are tried while i <= n / i;
// each one costs one pass of the shared bit-serial divider, which also
// yields the bound n / i. Zero gives 0 after one trial. The count
// saturates at 2047.
// req_tready is high only while the sequencer is idle; one item is worked
// on at a time. The result sits in an output register, so the next word is
// taken while a finished result still waits; the sequencer holds in its
// final state only if the register is still full when a second result is
// ready. Reset clears the sequencer and the output valid at once; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
`include "divisor_count_trial_assert.svh"

module divisor_count_trial #(
   parameter int NUM_WIDTH = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dct_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // [30:0] number
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dct_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata   // [10:0] divisor_total
);
   import dct_pkg::*;

   localparam int EXT_WIDTH = NUM_WIDTH + NUMBER_WIDTH;

   state_type               state_ff, state_in;
   logic [NUM_WIDTH-1:0]    num_ff, num_in;
   logic [NUM_WIDTH-1:0]    trial_ff, trial_in;
   logic [TOTAL_WIDTH-1:0]  total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_WIDTH-1:0]  rsp_total_ff, rsp_total_in;
   logic [EXT_WIDTH-1:0]    number_ext;
   logic [TOTAL_WIDTH:0]    total_sum;
   logic                    accept;
   logic                    div_start;
   div_status_type          div_stat;
   logic [NUM_WIDTH-1:0]    div_quo;
   logic [NUM_WIDTH-1:0]    div_rem;

   dct_div_unit #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff),
      .divisor   (trial_ff),
      .status    (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign number_ext = EXT_WIDTH'(req_tdata[NUMBER_WIDTH-1:0]);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      trial_in     = trial_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_total_in = rsp_total_ff;
      div_start    = 1'b0;
      total_sum    = {1'b0, total_ff} + ((div_quo == trial_ff) ? 12'd1 : 12'd2);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               num_in   = number_ext[NUM_WIDTH-1:0];
               trial_in = NUM_WIDTH'(1);
               total_in = '0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               if (trial_ff > div_quo) begin
                  state_in = ST_DONE;
               end else begin
                  if (div_rem == '0) begin
                     total_in = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                               : total_sum[TOTAL_WIDTH-1:0];
                  end
                  trial_in = trial_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff       <= num_in;
      trial_ff     <= trial_in;
      total_ff     <= total_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_total_ff);

   `DCT_ASSERT_NOW(a_done_in_divide, clock, reset, div_stat.done, state_ff == ST_DIVIDE)
   `DCT_ASSERT_NOW(a_trial_nonzero, clock, reset, div_start, trial_ff != '0)
   `DCT_ASSERT_NOW(a_idle_div_quiet, clock, reset, state_ff == ST_IDLE, !div_stat.busy)
   `DCT_ASSERT_NEXT(a_accept_init, clock, reset, accept,
                    state_ff == ST_START && total_ff == '0 && trial_ff == NUM_WIDTH'(1))

endmodule

/* hdl/dct_div_unit.sv */
// ---------------------------------------------------------------------------
// dct_div_unit
// Restoring divider, one quotient bit per cycle, with start/done handshake.
// ---------------------------------------------------------------------------
module dct_div_unit #(
   parameter int NUM_WIDTH = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_WIDTH-1:0]    dividend,
   input  logic [NUM_WIDTH-1:0]    divisor,
   output dct_pkg::div_status_type status,
   output logic [NUM_WIDTH-1:0]    quotient,
   output logic [NUM_WIDTH-1:0]    remainder
);
   import dct_pkg::*;

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   diff;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_WIDTH-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_WIDTH'(NUM_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_WIDTH-2:0], fits};
         rem_in = fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule
